>>> rtl/vertex_key_dedup_indexer_defines.svh
// ----------------------------------------------------------------------------
// vertex_key_dedup_indexer_defines.svh
// Assertion macros for the vertex key dedup indexer. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VERTEX_KEY_DEDUP_INDEXER_DEFINES_SVH
`define VERTEX_KEY_DEDUP_INDEXER_DEFINES_SVH

`ifndef SYNTHESIS

`define VKDI_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: label");

`define VKDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define VKDI_ASSERT_ALWAYS(label, clk, rst, expr)

`define VKDI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/vkdi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vkdi_pkg
// Shared constants and types of the vertex key dedup indexer: table geometry,
// entry layout and the structs between sequencer, table and top level.
// ----------------------------------------------------------------------------
package vkdi_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
   localparam int INDEX_BITS  = 20;
   localparam int FIELD_BITS  = 20;
   localparam int MODE_BITS   = 2;
   localparam int NUMBER_BITS = 10;
   localparam int COUNT_BITS  = NUMBER_BITS + 1;
   localparam int EPOCH_BITS  = 4;

   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
   localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = EPOCH_BITS'((1 << EPOCH_BITS) - 1);

   localparam int SUM_BITS  = (INDEX_BITS + 2 > SLOT_BITS) ? INDEX_BITS + 2 : SLOT_BITS;
   localparam int WIDE_BITS = (FIELD_BITS > INDEX_BITS) ? FIELD_BITS : INDEX_BITS;

   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [INDEX_BITS-1:0] index_type;

   // epoch 0 marks a cleared entry; live entries carry the current epoch
   typedef struct packed {
      logic [EPOCH_BITS-1:0]  epoch;
      index_type              pos;
      index_type              tex;
      index_type              nrm;
      logic [NUMBER_BITS-1:0] number;
   } entry_type;

   typedef struct packed {
      logic      en;
      slot_type  addr;
      entry_type data;
   } tbl_wr_type;

   typedef struct packed {
      logic                   valid;
      logic [NUMBER_BITS-1:0] number;
      logic                   is_new;
      logic                   full;
   } res_type;

   function automatic index_type mask_index(input logic [FIELD_BITS-1:0] v);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(v);
      return w[INDEX_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/vkdi_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vkdi_table
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module vkdi_table (
   input  wire logic                clock,
   input  wire vkdi_pkg::tbl_wr_type wr,
   input  wire vkdi_pkg::slot_type  rd_addr,
   output vkdi_pkg::entry_type      rd_data
);
   import vkdi_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/vkdi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vkdi_ctrl
// Probe sequencer: hashes the corner, walks the table one slot per cycle
// through a shared compare and increment, inserts or hits, and runs the
// clearing sweep.
// ----------------------------------------------------------------------------
module vkdi_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [vkdi_pkg::MODE_BITS-1:0]    key_mode,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_new_group,
   input  wire logic [vkdi_pkg::FIELD_BITS-1:0]   req_position_index,
   input  wire logic [vkdi_pkg::FIELD_BITS-1:0]   req_texcoord_index,
   input  wire logic [vkdi_pkg::FIELD_BITS-1:0]   req_normal_index,
   output logic                                   idle,
   output vkdi_pkg::res_type                      res,
   input  wire logic                              res_ready,
   output vkdi_pkg::tbl_wr_type                   tbl_wr,
   output vkdi_pkg::slot_type                     tbl_rd_addr,
   input  wire vkdi_pkg::entry_type               tbl_rd_data
);
   import vkdi_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_LOOKUP = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   localparam slot_type SLOT_LAST = SLOT_BITS'(TABLE_DEPTH - 1);

   logic [2:0]             state_ff, state_in;
   slot_type               clr_addr_ff, clr_addr_in;
   logic                   pending_ff, pending_in;
   logic [EPOCH_BITS-1:0]  epoch_ff, epoch_in;
   logic [COUNT_BITS-1:0]  next_number_ff, next_number_in;
   slot_type               slot_ff, slot_in;
   slot_type               probe_cnt_ff, probe_cnt_in;
   index_type              key_pos_ff, key_pos_in;
   index_type              key_tex_ff, key_tex_in;
   index_type              key_nrm_ff, key_nrm_in;
   logic [NUMBER_BITS-1:0] res_number_ff, res_number_in;
   logic                   res_new_ff, res_new_in;
   logic                   res_full_ff, res_full_in;

   logic                   req_fire;
   logic                   use_tex;
   logic                   use_nrm;
   index_type              in_pos;
   index_type              in_tex;
   index_type              in_nrm;
   logic [SUM_BITS-1:0]    hash_sum;
   logic                   entry_live;
   logic                   key_match;
   logic                   number_free;

   assign use_tex = key_mode[0];
   assign use_nrm = key_mode[1];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign idle      = (state_ff == ST_IDLE);

   assign in_pos = mask_index(req_position_index);
   assign in_tex = mask_index(req_texcoord_index);
   assign in_nrm = mask_index(req_normal_index);

   always_comb begin
      hash_sum = SUM_BITS'(in_pos);
      if (use_tex) begin
         hash_sum = hash_sum + SUM_BITS'(in_tex);
      end
      if (use_nrm) begin
         hash_sum = hash_sum + SUM_BITS'(in_nrm);
      end
   end

   assign entry_live  = (tbl_rd_data.epoch == epoch_ff);
   assign key_match   = (tbl_rd_data.pos == key_pos_ff)
                     && (!use_tex || (tbl_rd_data.tex == key_tex_ff))
                     && (!use_nrm || (tbl_rd_data.nrm == key_nrm_ff));
   assign number_free = (next_number_ff[NUMBER_BITS] == 1'b0);

   // in CHECK, prefetch the next slot so a miss stays in CHECK without passing through LOOKUP
   assign tbl_rd_addr = (state_ff == ST_CHECK) ? slot_ff + SLOT_BITS'(1) : slot_ff;

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      pending_in     = pending_ff;
      epoch_in       = epoch_ff;
      next_number_in = next_number_ff;
      slot_in        = slot_ff;
      probe_cnt_in   = probe_cnt_ff;
      key_pos_in     = key_pos_ff;
      key_tex_in     = key_tex_ff;
      key_nrm_in     = key_nrm_ff;
      res_number_in  = res_number_ff;
      res_new_in     = res_new_ff;
      res_full_in    = res_full_ff;
      tbl_wr         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_pos_in   = in_pos;
               key_tex_in   = in_tex;
               key_nrm_in   = in_nrm;
               slot_in      = hash_sum[SLOT_BITS-1:0];
               probe_cnt_in = '0;
               state_in     = ST_LOOKUP;
               if (req_new_group) begin
                  next_number_in = '0;
                  if (epoch_ff == EPOCH_LAST) begin
                     // epochs exhausted: sweep the table before this request
                     epoch_in    = EPOCH_FIRST;
                     clr_addr_in = '0;
                     pending_in  = 1'b1;
                     state_in    = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_BITS'(1);
                  end
               end
            end
         end
         ST_CLEAR: begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + SLOT_BITS'(1);
            if (clr_addr_ff == SLOT_LAST) begin
               pending_in = 1'b0;
               state_in   = pending_ff ? ST_LOOKUP : ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!entry_live) begin
               res_new_in    = number_free;
               res_full_in   = !number_free;
               res_number_in = number_free ? next_number_ff[NUMBER_BITS-1:0] : '0;
               if (number_free) begin
                  tbl_wr.en          = 1'b1;
                  tbl_wr.addr        = slot_ff;
                  tbl_wr.data.epoch  = epoch_ff;
                  tbl_wr.data.pos    = key_pos_ff;
                  tbl_wr.data.tex    = key_tex_ff;
                  tbl_wr.data.nrm    = key_nrm_ff;
                  tbl_wr.data.number = next_number_ff[NUMBER_BITS-1:0];
                  next_number_in     = next_number_ff + COUNT_BITS'(1);
               end
               state_in = ST_DONE;
            end else if (key_match) begin
               res_new_in    = 1'b0;
               res_full_in   = 1'b0;
               res_number_in = tbl_rd_data.number;
               state_in      = ST_DONE;
            end else if (probe_cnt_ff == SLOT_LAST) begin
               res_new_in    = 1'b0;
               res_full_in   = 1'b1;
               res_number_in = '0;
               state_in      = ST_DONE;
            end else begin
               slot_in      = slot_ff + SLOT_BITS'(1);
               probe_cnt_in = probe_cnt_ff + SLOT_BITS'(1);
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         pending_ff     <= 1'b0;
         epoch_ff       <= EPOCH_FIRST;
         next_number_ff <= '0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         pending_ff     <= pending_in;
         epoch_ff       <= epoch_in;
         next_number_ff <= next_number_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      probe_cnt_ff  <= probe_cnt_in;
      key_pos_ff    <= key_pos_in;
      key_tex_ff    <= key_tex_in;
      key_nrm_ff    <= key_nrm_in;
      res_number_ff <= res_number_in;
      res_new_ff    <= res_new_in;
      res_full_ff   <= res_full_in;
   end

   assign res.valid  = (state_ff == ST_DONE);
   assign res.number = res_number_ff;
   assign res.is_new = res_new_ff;
   assign res.full   = res_full_ff;

endmodule
`default_nettype wire

>>> rtl/vertex_key_dedup_indexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_key_dedup_indexer
// Assigns dense vertex numbers to face corners through a hashed corner table.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one face corner per request (valid/stall). req_new_group clears
//            the table and restarts numbering before the corner is handled.
//   rsp_*  : one result per request: vertex number, is_new, table_full.
//   csr_*  : key_mode write (valid/ready); write only while no request is
//            in flight.
// Sequence:
//   An accepted request passes through a table read (LOOKUP), the CHECK
//   state, which probes one table slot after another through the shared
//   compare and increment, and DONE, from which the result enters the output
//   register; a new request is taken only after that. Probe length is bounded
//   by the table depth. Every 15th new group costs a clearing sweep of the
//   whole table before that request is handled.
// Reset:
//   Synchronous reset starts a clearing sweep of the whole table; req_stall
//   is high until it ends. key_mode returns to position only.
// Backpressure:
//   A result held under rsp_stall stays in the output register; the next
//   request is still accepted and processed, and waits for the register.
// ----------------------------------------------------------------------------
`include "vertex_key_dedup_indexer_defines.svh"

module vertex_key_dedup_indexer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_new_group,
   input  wire logic [vkdi_pkg::FIELD_BITS-1:0]   req_position_index,
   input  wire logic [vkdi_pkg::FIELD_BITS-1:0]   req_texcoord_index,
   input  wire logic [vkdi_pkg::FIELD_BITS-1:0]   req_normal_index,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [vkdi_pkg::NUMBER_BITS-1:0]       rsp_vertex_number,
   output logic                                   rsp_is_new,
   output logic                                   rsp_table_full,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [vkdi_pkg::MODE_BITS-1:0]    csr_key_mode
);
   import vkdi_pkg::*;

   logic [MODE_BITS-1:0]   key_mode_ff, key_mode_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NUMBER_BITS-1:0] rsp_number_ff, rsp_number_in;
   logic                   rsp_new_ff, rsp_new_in;
   logic                   rsp_full_ff, rsp_full_in;

   logic                   ctrl_idle;
   res_type                res;
   logic                   res_ready;
   tbl_wr_type             tbl_wr;
   slot_type               tbl_rd_addr;
   entry_type              tbl_rd_data;

   vkdi_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .key_mode           (key_mode_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_new_group      (req_new_group),
      .req_position_index (req_position_index),
      .req_texcoord_index (req_texcoord_index),
      .req_normal_index   (req_normal_index),
      .idle               (ctrl_idle),
      .res                (res),
      .res_ready          (res_ready),
      .tbl_wr             (tbl_wr),
      .tbl_rd_addr        (tbl_rd_addr),
      .tbl_rd_data        (tbl_rd_data)
   );

   vkdi_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign csr_ready = ctrl_idle;
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      key_mode_in   = key_mode_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_number_in = rsp_number_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_full_in   = rsp_full_ff;
      if (csr_valid && csr_ready) begin
         key_mode_in = csr_key_mode;
      end
      if (res.valid && res_ready) begin
         rsp_valid_in  = 1'b1;
         rsp_number_in = res.number;
         rsp_new_in    = res.is_new;
         rsp_full_in   = res.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_mode_ff  <= key_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_number_ff <= rsp_number_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_number = rsp_number_ff;
   assign rsp_is_new        = rsp_new_ff;
   assign rsp_table_full    = rsp_full_ff;

   `VKDI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `VKDI_ASSERT_ALWAYS(a_full_not_new, clock, reset, !(rsp_valid && rsp_is_new && rsp_table_full))
   `VKDI_ASSERT_ALWAYS(a_full_zero_number, clock, reset, !(rsp_valid && rsp_table_full) || (rsp_vertex_number == '0))
   `VKDI_ASSERT_NEXT(a_csr_only_idle, clock, reset, csr_valid && csr_ready, !res.valid)

endmodule
`default_nettype wire
